>>> rtl/hashed_set_lru_cache_insert_top_macros.svh
// Assertion macros shared by the cache RTL.
`ifndef HASHED_SET_LRU_CACHE_INSERT_TOP_MACROS_SVH
`define HASHED_SET_LRU_CACHE_INSERT_TOP_MACROS_SVH
// Implication checked every clock outside reset.
`define HSLC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define HSLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/hslc_pkg.sv
// Package: types and constants of the set-associative LRU insert cache.
`default_nettype none
package hslc_pkg;
   localparam int SETS = 8;
   localparam int WAYS = 8;
   localparam int SET_BITS = $clog2(SETS);
   localparam int WAY_BITS = $clog2(WAYS);
   localparam int RANK_BITS = $clog2(WAYS);
   localparam int LINES = SETS * WAYS;
   localparam int USED_BITS = $clog2(WAYS + 1);
   localparam logic [3:0] COUNT_MAX = 4'd15;
   localparam logic [3:0] LIMIT_RESET = 4'd6;

   typedef struct packed {
      logic [39:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic        inserted;
      logic        evicted;
      logic [39:0] evicted_key;
      logic [31:0] evicted_value;
      logic        over_limit;
      logic [3:0]  entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic load_req;
      logic read_set;
      logic update;
   } cmd_type;
endpackage
`default_nettype wire

>>> rtl/hashed_set_lru_cache_insert_top.sv
// Top level: hashed set-associative insert cache with per-set LRU replacement.
`default_nettype none
// Each request item inserts key/value into set key[2:0] of an 8-set, 8-way
// store. A hit only refreshes LRU order and reports inserted=0; a miss bumps
// the saturating global count and, if the set is nonempty and the count now
// exceeds element_limit (or the set is full), evicts the set's least recent
// entry and reports it. Timing: after the accepting edge the set row is read,
// then compare/update loads the result register, and rsp_valid rises and holds
// until the result is taken; the next item is accepted in the cycle its
// result is taken, so items are handled one at a time by the
// single-row read-modify-write of the set store. csr writes (element_limit,
// 4 bits) are always ready and must only be issued while the block is idle.
// Reset clears valid bits, ranks, count and restores limit to 6.
module hashed_set_lru_cache_insert_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  hslc_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output hslc_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [3:0]        csr_data
);
   hslc_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   hslc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_ready, .rsp_valid, .cmd
   );

   hslc_datapath u_dp (
      .clock, .reset, .cmd, .req_data, .csr_valid, .csr_data, .rsp_data
   );
endmodule
`default_nettype wire

>>> rtl/hslc_ctrl.sv
// Controller: sequences accept, set read, update and result handoff.
`default_nettype none
module hslc_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output hslc_pkg::cmd_type     cmd
);
   hslc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hslc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hslc_pkg::ST_IDLE: begin
            if (req_valid) state_in = hslc_pkg::ST_READ;
         end
         hslc_pkg::ST_READ: state_in = hslc_pkg::ST_UPDATE;
         hslc_pkg::ST_UPDATE: state_in = hslc_pkg::ST_HOLD;
         hslc_pkg::ST_HOLD: begin
            if (rsp_ready) state_in = req_valid ? hslc_pkg::ST_READ : hslc_pkg::ST_IDLE;
         end
         default: state_in = hslc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd = '0;
      case (state_ff)
         hslc_pkg::ST_IDLE: req_ready = 1'b1;
         hslc_pkg::ST_READ: cmd.read_set = 1'b1;
         hslc_pkg::ST_UPDATE: cmd.update = 1'b1;
         hslc_pkg::ST_HOLD: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
         end
         default: ;
      endcase
      cmd.load_req = req_valid && req_ready;
   end

   `include "hashed_set_lru_cache_insert_top_macros.svh"
   `HSLC_ASSERT_NEXT(a_accept_reads, clock, reset, req_valid && req_ready,
      state_ff == hslc_pkg::ST_READ, "accepted item not read next")
   `HSLC_ASSERT_NEXT(a_update_hold, clock, reset, cmd.update,
      rsp_valid, "update not followed by result")
   `HSLC_ASSERT_IMPL(a_one_phase, clock, reset, 1'b1,
      $onehot0({cmd.read_set, cmd.update, rsp_valid}), "phases overlap")
endmodule
`default_nettype wire

>>> rtl/hslc_datapath.sv
// Datapath: set arrays, tag compare, LRU ranks, victim pick and count.
`default_nettype none
module hslc_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  hslc_pkg::cmd_type      cmd,
   input  hslc_pkg::req_type      req_data,
   input  wire logic              csr_valid,
   input  wire logic [3:0]        csr_data,
   output hslc_pkg::rsp_type      rsp_data
);
   localparam int W = hslc_pkg::WAYS;

   // key/value store: one row per set, all ways of a row read together
   logic [W-1:0][39:0] key_mem [hslc_pkg::SETS];
   logic [W-1:0][31:0] val_mem [hslc_pkg::SETS];
   logic [W-1:0][39:0] key_rd_ff;
   logic [W-1:0][31:0] val_rd_ff;

   logic [W-1:0] valid_ff [hslc_pkg::SETS];
   logic [W-1:0][hslc_pkg::RANK_BITS-1:0] rank_ff [hslc_pkg::SETS];
   logic [W-1:0] vrow_ff;
   logic [W-1:0][hslc_pkg::RANK_BITS-1:0] rrow_ff;

   hslc_pkg::req_type req_ff;
   hslc_pkg::rsp_type rsp_ff, rsp_in;
   logic [3:0] count_ff, count_in;
   logic [3:0] limit_ff;

   logic [hslc_pkg::SET_BITS-1:0] set_idx;
   assign set_idx = req_ff.key[hslc_pkg::SET_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_data;
      if (cmd.read_set) begin
         key_rd_ff <= key_mem[set_idx];
         val_rd_ff <= val_mem[set_idx];
      end
      if (cmd.update) rsp_ff <= rsp_in;
   end

   // update logic
   logic hit, evict, do_write;
   logic [hslc_pkg::WAY_BITS-1:0] hit_way, vic_way, slot_way;
   logic slot_found;
   logic [hslc_pkg::USED_BITS-1:0] used;
   logic [3:0] newc;
   logic [W-1:0] vrow_in;
   logic [W-1:0][hslc_pkg::RANK_BITS-1:0] rrow_in;

   always_comb begin
      hit = 1'b0; hit_way = '0; vic_way = '0; used = '0;
      slot_found = 1'b0; slot_way = '0;
      for (int w = 0; w < W; w++) begin
         if (vrow_ff[w]) begin
            used = used + 1'b1;
            if (key_rd_ff[w] == req_ff.key) begin
               hit = 1'b1; hit_way = w[hslc_pkg::WAY_BITS-1:0];
            end
            if (rrow_ff[w] > rrow_ff[vic_way] || !vrow_ff[vic_way])
               vic_way = w[hslc_pkg::WAY_BITS-1:0];
         end
      end
      newc = (count_ff < hslc_pkg::COUNT_MAX) ? count_ff + 4'd1 : hslc_pkg::COUNT_MAX;
      evict = !hit && (used != '0) &&
              (newc > limit_ff || used >= hslc_pkg::USED_BITS'(W));
      vrow_in = vrow_ff;
      rrow_in = rrow_ff;
      if (hit) begin
         for (int w = 0; w < W; w++)
            if (vrow_ff[w] && rrow_ff[w] < rrow_ff[hit_way]) rrow_in[w] = rrow_ff[w] + 1'b1;
         rrow_in[hit_way] = '0;
      end else begin
         if (evict) begin
            vrow_in[vic_way] = 1'b0;
            rrow_in[vic_way] = '0;
            if (newc != 4'd0) newc = newc - 4'd1;
         end
         for (int w = 0; w < W; w++) begin
            if (vrow_in[w]) rrow_in[w] = rrow_in[w] + 1'b1;
            else if (!slot_found) begin
               slot_found = 1'b1; slot_way = w[hslc_pkg::WAY_BITS-1:0];
            end
         end
         if (slot_found) begin
            vrow_in[slot_way] = 1'b1;
            rrow_in[slot_way] = '0;
         end
      end
      do_write = !hit && slot_found;
      count_in = hit ? count_ff : newc;
      rsp_in.inserted = !hit;
      rsp_in.evicted = evict;
      rsp_in.evicted_key = evict ? key_rd_ff[vic_way] : '0;
      rsp_in.evicted_value = evict ? val_rd_ff[vic_way] : '0;
      rsp_in.over_limit = count_in > limit_ff;
      rsp_in.entry_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.update && do_write) begin
         key_mem[set_idx][slot_way] <= req_ff.key;
         val_mem[set_idx][slot_way] <= req_ff.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < hslc_pkg::SETS; s++) begin
            valid_ff[s] <= '0;
            rank_ff[s] <= '0;
         end
         count_ff <= '0;
         limit_ff <= hslc_pkg::LIMIT_RESET;
      end else begin
         if (csr_valid) limit_ff <= csr_data;
         if (cmd.read_set) begin
            vrow_ff <= valid_ff[set_idx];
            rrow_ff <= rank_ff[set_idx];
         end
         if (cmd.update) begin
            valid_ff[set_idx] <= vrow_in;
            rank_ff[set_idx] <= rrow_in;
            count_ff <= count_in;
         end
      end
   end

   assign rsp_data = rsp_ff;

   `include "hashed_set_lru_cache_insert_top_macros.svh"
   `HSLC_ASSERT_IMPL(a_hit_no_evict, clock, reset, cmd.update && hit,
      !evict && count_in == count_ff, "hit changed count or evicted")
   `HSLC_ASSERT_NEXT(a_count_step, clock, reset, cmd.update && !hit && !evict
      && count_ff != hslc_pkg::COUNT_MAX, count_ff == $past(count_ff) + 4'd1,
      "miss count step wrong")
   `HSLC_ASSERT_IMPL(a_miss_slot, clock, reset, cmd.update && !hit,
      slot_found, "miss found no free way")
endmodule
`default_nettype wire

>>> dv/tb.sv
// Testbench for the hashed set-associative LRU insert cache.
`timescale 1ns / 1ps
module tb;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   hslc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   hslc_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [3:0] csr_data = '0;
   logic req_ready_q = 1'b0;      // item taken at the last rising edge

   hashed_set_lru_cache_insert_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: shadow copy of the set store.
   logic [39:0] shadow_key [hslc_pkg::LINES];
   logic [31:0] shadow_val [hslc_pkg::LINES];
   logic        shadow_vld [hslc_pkg::LINES];
   logic [2:0]  shadow_rank [hslc_pkg::LINES];
   logic [3:0]  shadow_count;
   logic [3:0]  shadow_limit;

   hslc_pkg::req_type pending_reqs[$];      // items waiting for the driver
   hslc_pkg::rsp_type expected_rsps[$];     // predicted results, oldest first
   int      errors = 0;
   int      send_idle = 29;       // percent of cycles the sender idles
   int      recv_idle = 71;       // percent of cycles the receiver stalls
   int      hits = 0, evicts = 0, sent = 0, got = 0;
   longint  cycles = 0;

   function automatic void clear_shadow();
      for (int i = 0; i < hslc_pkg::LINES; i++) begin
         shadow_vld[i] = 1'b0;
         shadow_rank[i] = '0;
         shadow_key[i] = '0;
         shadow_val[i] = '0;
      end
      shadow_count = '0;
      shadow_limit = hslc_pkg::LIMIT_RESET;
   endfunction

   // Compute the result of one insert and update the shadow store.
   function automatic hslc_pkg::rsp_type predict_insert(hslc_pkg::req_type r);
      hslc_pkg::rsp_type o;
      int base, hit, victim, slot, used;
      logic [4:0] newc;
      logic [2:0] hr;
      o = '0;
      base = int'(r.key[2:0]) * hslc_pkg::WAYS;
      hit = -1; victim = -1; slot = -1; used = 0;
      for (int w = 0; w < hslc_pkg::WAYS; w++) begin
         if (shadow_vld[base+w]) begin
            used++;
            if (shadow_key[base+w] == r.key) hit = base + w;
            if (victim < 0 || shadow_rank[base+w] > shadow_rank[victim]) victim = base + w;
         end
      end
      if (hit >= 0) begin
         hr = shadow_rank[hit];
         for (int w = 0; w < hslc_pkg::WAYS; w++)
            if (shadow_vld[base+w] && shadow_rank[base+w] < hr)
               shadow_rank[base+w]++;
         shadow_rank[hit] = '0;
         o.over_limit = shadow_count > shadow_limit;
         o.entry_count = shadow_count;
         hits++;
         return o;
      end
      newc = (shadow_count < hslc_pkg::COUNT_MAX) ? shadow_count + 5'd1
                                                  : 5'(hslc_pkg::COUNT_MAX);
      if (used > 0 && (newc > shadow_limit || used >= hslc_pkg::WAYS)) begin
         o.evicted = 1'b1;
         o.evicted_key = shadow_key[victim];
         o.evicted_value = shadow_val[victim];
         shadow_vld[victim] = 1'b0;
         shadow_rank[victim] = '0;
         if (newc > 0) newc--;
         evicts++;
      end
      for (int w = 0; w < hslc_pkg::WAYS; w++) begin
         if (shadow_vld[base+w]) shadow_rank[base+w]++;
         else if (slot < 0) slot = base + w;
      end
      if (slot >= 0) begin
         shadow_key[slot] = r.key;
         shadow_val[slot] = r.value;
         shadow_vld[slot] = 1'b1;
         shadow_rank[slot] = '0;
      end
      shadow_count = newc[3:0];
      o.inserted = 1'b1;
      o.over_limit = shadow_count > shadow_limit;
      o.entry_count = shadow_count;
      return o;
   endfunction

   // Driver: presents queued items at the falling edge, holds until taken.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready_q) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Handshake sampled at the rising edge for the driver's next decision.
   always @(posedge clock) begin
      req_ready_q <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         expected_rsps.push_back(predict_insert(req_data));
         sent++;
      end
   end

   // Monitor: compares each taken result with the oldest prediction.
   always @(posedge clock) begin
      hslc_pkg::rsp_type exp_r;
      cycles++;
      if (!reset && rsp_valid && rsp_ready) begin
         got++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            errors++;
         end else begin
            exp_r = expected_rsps.pop_front();
            if (rsp_data !== exp_r) begin
               $display("%0t: mismatch expected %h actual %h", $time, exp_r, rsp_data);
               errors++;
            end
         end
      end
      if (cycles > 400000) begin
         $display("timeout after %0d cycles", cycles);
         $display("** hashed_set_lru_cache_insert_top: FAILED **");
         $finish;
      end
   end

   // Wait until every queued item is taken and every result has come back.
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid) @(posedge clock);
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(logic [3:0] lim);
      @(negedge clock);
      csr_data <= lim;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_limit = lim;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic hslc_pkg::req_type make_req(logic [39:0] k, logic [31:0] v);
      hslc_pkg::req_type r;
      r.key = k;
      r.value = v;
      return r;
   endfunction

   // Random key: mostly from a small pool per set so hits and LRU reuse occur.
   function automatic logic [39:0] rand_key();
      logic [39:0] k;
      k = 40'({$urandom, $urandom});
      if ($urandom_range(99) < 80) k[39:3] = 37'($urandom_range(11));
      return k;
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++)
         pending_reqs.push_back(make_req(rand_key(), $urandom));
      drain();
   endtask

   initial begin
      clear_shadow();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, hits, a full set, count saturation.
      pending_reqs.push_back(make_req('0, '0));
      pending_reqs.push_back(make_req('0, '1));                 // hit
      pending_reqs.push_back(make_req('1, '1));
      pending_reqs.push_back(make_req(40'hAA_AAAA_AAA8, 32'h5555_5555));
      pending_reqs.push_back(make_req(40'h55_5555_5550, 32'hAAAA_AAAA));
      drain();
      write_limit(4'd15);                                        // above range
      for (int i = 1; i <= 9; i++)                               // fill set 5
         pending_reqs.push_back(make_req({37'(i), 3'd5}, 32'(i)));
      pending_reqs.push_back(make_req({37'd3, 3'd5}, 32'd0));   // hit mid-rank
      for (int s = 0; s < 8; s++)                                // saturate count
         pending_reqs.push_back(make_req({37'(100 + s), 3'(s)}, 32'(s)));
      drain();
      write_limit(4'd0);                                         // zero limit
      pending_reqs.push_back(make_req({37'd7, 3'd6}, 32'd1));
      pending_reqs.push_back(make_req({37'd8, 3'd6}, 32'd2));
      drain();

      // Random phases across limit settings and idling profiles.
      write_limit(4'd1);
      random_phase(300);
      write_limit(4'd8);
      random_phase(300);
      send_idle = 71; recv_idle = 29;
      write_limit(4'd6);
      random_phase(300);
      write_limit(4'($urandom_range(2, 7)));
      random_phase(300);
      send_idle = 0; recv_idle = 0;
      write_limit(4'd4);
      random_phase(350);
      write_limit(4'd15);
      random_phase(350);

      $display("covered %0d items, %0d results, %0d hits, %0d evictions",
               sent, got, hits, evicts);
      $display("limits 0, 1, 4, 6, 8 and 15 under three idling profiles");
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("** hashed_set_lru_cache_insert_top: PASSED **");
      end else begin
         $display("** hashed_set_lru_cache_insert_top: FAILED **");
      end
      $finish;
   end
endmodule
